// ===== hdl/two_phase_cell_state_converter_core_assert.svh =====
// assertion macros for the two-phase cell state converter
// expects clk_i and rst_ni in the scope of use
`ifndef TWO_PHASE_CELL_STATE_CONVERTER_CORE_ASSERT_SVH
`define TWO_PHASE_CELL_STATE_CONVERTER_CORE_ASSERT_SVH
`ifndef SYNTH
`define TPCSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tpcsc: assertion failed");
`define TPCSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) \
    else $error("tpcsc: assertion failed");
`else
`define TPCSC_ASSERT(lbl, prop)
`define TPCSC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/tpcsc_pkg.sv =====
// shared types, constants and fixed-point helpers of the cell state converter
// no dependencies
package tpcsc_pkg;

  localparam int DIV_QW   = 33;
  localparam int ALPHA_QW = 17;

  localparam logic [15:0]        ALPHA_MAX = 16'd65470;
  localparam logic [16:0]        ONE_Q16   = 17'd65536;
  localparam logic signed [31:0] S32_MAX   = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN   = 32'sh80000000;

  typedef struct packed {
    logic              req;
    logic [15:0]       idx;
    logic signed [31:0] vol;
    logic signed [31:0] mm;
    logic signed [31:0] mg;
    logic signed [31:0] mom;
    logic signed [31:0] rg;
    logic signed [31:0] rl;
  } cell_t;

  typedef struct packed {
    logic signed [31:0] mmix;
    logic signed [31:0] mgas;
    logic signed [31:0] mom;
  } cons_t;

  typedef struct packed {
    cell_t rec;
    cons_t cons;
  } s1_t;

  typedef struct packed {
    cell_t              rec;
    cons_t              cons;
    logic signed [31:0] rho;
    logic signed [31:0] g;
  } s2_t;

  typedef struct packed {
    cell_t              rec;
    cons_t              cons;
    logic signed [31:0] rho;
    logic [15:0]        alpha;
    logic signed [31:0] sg;
    logic signed [31:0] sl;
  } s3_t;

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  // q16 product: floor shift by 16, then saturate
  function automatic logic signed [31:0] mulq_sat(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> 16;
    if (s > 64'sd2147483647) return S32_MAX;
    if (s < -64'sd2147483648) return S32_MIN;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v > 33'sd2147483647) return S32_MAX;
    if (v < -33'sd2147483648) return S32_MIN;
    return v[31:0];
  endfunction

  // signed-magnitude quotient to saturated 32-bit value
  function automatic logic signed [31:0] div_sat32(input logic [DIV_QW-1:0] q,
                                                   input logic ovf, input logic neg);
    logic [DIV_QW-1:0] nq;
    nq = ~q + {{(DIV_QW-1){1'b0}}, 1'b1};
    if (neg) begin
      if (ovf || q > 33'd2147483648) return S32_MIN;
      return nq[31:0];
    end
    if (ovf || q > 33'd2147483647) return S32_MAX;
    return q[31:0];
  endfunction

endpackage

// ===== hdl/two_phase_cell_state_converter_core.sv =====
// top level of the two-phase cell state converter
// depends on tpcsc_pkg, tpcsc_div and the assertion macro header
//
// Usage:
//   input channel: in_valid_i / in_stall_o with one cell record per transaction;
//   req_type_i = 1 turns primitives into conserved mass, gas mass and momentum,
//   req_type_i = 0 turns conserved values into primitives and phase velocities.
//   output channel: out_valid_o / out_stall_i, one result per input transaction,
//   in input order, tagged with the cell index.
//   config channel: cfg_valid_i / cfg_ready_o writes the slip velocity; ready is
//   always high. Write it only while no transaction is in flight.
// Timing:
//   95 register stages between input and output. One transaction per cycle is
//   taken without bubbles while the output is not stalled. The depth is
//   set by three chained long divisions (33, 17 and 33 quotient bits, one bit
//   per stage) plus the multiply, fixup and output stages around them.
// Reset and stall:
//   reset clears all valid bits and the slip velocity to zero. While a result is
//   held on a stalled output the whole pipeline freezes and in_stall_o is high;
//   nothing is dropped or repeated.
`include "two_phase_cell_state_converter_core_assert.svh"

module two_phase_cell_state_converter_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic signed [31:0]  cfg_slip_velocity_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                req_type_i,
  input  logic [15:0]         cell_index_i,
  input  logic signed [31:0]  cell_volume_i,
  input  logic signed [31:0]  mass_mixture_in_i,
  input  logic signed [31:0]  mass_gas_in_i,
  input  logic signed [31:0]  momentum_in_i,
  input  logic signed [31:0]  gas_density_in_i,
  input  logic signed [31:0]  liquid_density_in_i,
  input  logic signed [31:0]  mixture_density_in_i,
  input  logic [16:0]         void_fraction_in_i,
  input  logic signed [31:0]  mixture_velocity_in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [15:0]         cell_tag_o,
  output logic                volume_error_o,
  output logic signed [31:0]  mixture_density_out_o,
  output logic [15:0]         void_fraction_out_o,
  output logic signed [31:0]  liquid_density_out_o,
  output logic signed [31:0]  mixture_velocity_out_o,
  output logic signed [31:0]  gas_velocity_out_o,
  output logic signed [31:0]  liquid_velocity_out_o,
  output logic signed [31:0]  mass_mixture_out_o,
  output logic signed [31:0]  mass_gas_out_o,
  output logic signed [31:0]  momentum_out_o
);
  import tpcsc_pkg::*;

  logic adv;
  logic signed [31:0] slip_q;

  // front stages: primitive to conserved products
  logic               f1_vld_q, f2_vld_q, f3_vld_q, f4_vld_q;
  cell_t              f1_cell_q, f2_cell_q, f3_cell_q, f4_cell_q;
  logic signed [63:0] f1_a_q, f1_b_q, f1_c_q;
  logic signed [31:0] f2_mmix_q, f2_t2_q, f2_t3_q, f3_mmix_q;
  logic signed [63:0] f3_d_q, f3_e_q;
  cons_t              f4_cons_q;
  cell_t              in_cell;

  // first divide: mixture and gas density
  s1_t                     d1_in;
  logic                    d1_vld;
  logic [DIV_QW-1:0]       d1r_quo, d1g_quo;
  logic                    d1r_ovf, d1r_neg, d1g_ovf, d1g_neg;
  logic [$bits(s1_t)-1:0]  d1_side;
  s1_t                     d1_s;
  logic signed [31:0]      rho_raw, g_val;
  s2_t                     r_d;
  logic                    r_vld_q;
  s2_t                     r_s_q;

  // second divide: void fraction
  logic                    d2_vld;
  logic [ALPHA_QW-1:0]     d2_quo;
  logic                    d2_ovf, d2_neg;
  logic [$bits(s2_t)-1:0]  d2_side;
  s2_t                     d2_s;
  logic [15:0]             alpha_d;
  logic                    a_vld_q, b_vld_q, c_vld_q;
  s2_t                     a_s_q, b_s_q;
  logic [15:0]             a_alpha_q, b_alpha_q;
  logic signed [63:0]      b_ar_q, b_rv_q, b_pg_q, b_pl_q;
  s3_t                     c_d, c_s_q;
  logic signed [63:0]      c_nrl_q, c_rv_q;
  logic [63:0]             nrl_mag, rv_mag;

  // third divide: liquid density and mixture velocity
  logic                    d3_vld;
  logic [DIV_QW-1:0]       d3l_quo, d3v_quo;
  logic                    d3l_ovf, d3l_neg, d3v_ovf, d3v_neg;
  logic [$bits(s3_t)-1:0]  d3_side;
  s3_t                     d3_s;
  logic signed [31:0]      rl_new, vm_raw, vm, vg, vl;

  // output registers
  logic               out_valid_q;
  logic [15:0]        cell_tag_q;
  logic               err_q;
  logic signed [31:0] rho_q, rl_q, vm_q;
  logic signed [31:0] vg_q, vl_q;
  logic [15:0]        alpha_q;
  logic signed [31:0] mmix_q, mgas_q, mom_q;

  // the whole pipeline moves unless a finished result is being held
  assign adv         = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slip_q <= '0;
    end else if (cfg_valid_i) begin
      slip_q <= cfg_slip_velocity_i;
    end
  end

  assign in_cell = '{req: req_type_i, idx: cell_index_i, vol: cell_volume_i,
                     mm: mass_mixture_in_i, mg: mass_gas_in_i, mom: momentum_in_i,
                     rg: gas_density_in_i, rl: liquid_density_in_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q    <= 1'b0;
      f2_vld_q    <= 1'b0;
      f3_vld_q    <= 1'b0;
      f4_vld_q    <= 1'b0;
      r_vld_q     <= 1'b0;
      a_vld_q     <= 1'b0;
      b_vld_q     <= 1'b0;
      c_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      f1_vld_q    <= in_valid_i;
      f2_vld_q    <= f1_vld_q;
      f3_vld_q    <= f2_vld_q;
      f4_vld_q    <= f3_vld_q;
      r_vld_q     <= d1_vld;
      a_vld_q     <= d2_vld;
      b_vld_q     <= a_vld_q;
      c_vld_q     <= b_vld_q;
      out_valid_q <= d3_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_cell_q <= in_cell;
      f1_a_q    <= 64'(mixture_density_in_i) * 64'(cell_volume_i);
      f1_b_q    <= 64'(signed'({1'b0, void_fraction_in_i})) * 64'(gas_density_in_i);
      f1_c_q    <= 64'(mixture_density_in_i) * 64'(mixture_velocity_in_i);

      f2_cell_q <= f1_cell_q;
      f2_mmix_q <= mulq_sat(f1_a_q);
      f2_t2_q   <= mulq_sat(f1_b_q);
      f2_t3_q   <= mulq_sat(f1_c_q);

      f3_cell_q <= f2_cell_q;
      f3_mmix_q <= f2_mmix_q;
      f3_d_q    <= 64'(f2_t2_q) * 64'(f2_cell_q.vol);
      f3_e_q    <= 64'(f2_t3_q) * 64'(f2_cell_q.vol);

      f4_cell_q <= f3_cell_q;
      f4_cons_q <= '{mmix: f3_mmix_q, mgas: mulq_sat(f3_d_q), mom: mulq_sat(f3_e_q)};
    end
  end

  assign d1_in = '{rec: f4_cell_q, cons: f4_cons_q};

  tpcsc_div #(
    .NUM_W (48), .DEN_W (32), .Q_W (DIV_QW), .SIDE_W ($bits(s1_t))
  ) u_div_rho (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (f4_vld_q),
    .num_i   ({abs32(f4_cell_q.mm), 16'd0}),
    .den_i   (abs32(f4_cell_q.vol)),
    .neg_i   (f4_cell_q.mm[31] ^ f4_cell_q.vol[31]),
    .side_i  (d1_in),
    .valid_o (d1_vld),
    .quo_o   (d1r_quo),
    .ovf_o   (d1r_ovf),
    .neg_o   (d1r_neg),
    .side_o  (d1_side)
  );

  tpcsc_div #(
    .NUM_W (48), .DEN_W (32), .Q_W (DIV_QW), .SIDE_W (1)
  ) u_div_gas (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (f4_vld_q),
    .num_i   ({abs32(f4_cell_q.mg), 16'd0}),
    .den_i   (abs32(f4_cell_q.vol)),
    .neg_i   (f4_cell_q.mg[31] ^ f4_cell_q.vol[31]),
    .side_i  (1'b0),
    .valid_o (),
    .quo_o   (d1g_quo),
    .ovf_o   (d1g_ovf),
    .neg_o   (d1g_neg),
    .side_o  ()
  );

  assign d1_s    = s1_t'(d1_side);
  assign rho_raw = div_sat32(d1r_quo, d1r_ovf, d1r_neg);
  assign g_val   = div_sat32(d1g_quo, d1g_ovf, d1g_neg);

  // non-positive density falls back to half the old liquid density
  always_comb begin
    r_d      = '0;
    r_d.rec  = d1_s.rec;
    r_d.cons = d1_s.cons;
    r_d.g    = g_val;
    r_d.rho  = (rho_raw <= 0) ? (d1_s.rec.rl >>> 1) : rho_raw;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_s_q <= r_d;
    end
  end

  tpcsc_div #(
    .NUM_W (48), .DEN_W (32), .Q_W (ALPHA_QW), .SIDE_W ($bits(s2_t))
  ) u_div_alpha (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (r_vld_q),
    .num_i   ({abs32(r_s_q.g), 16'd0}),
    .den_i   (abs32(r_s_q.rec.rg)),
    .neg_i   (r_s_q.g[31] ^ r_s_q.rec.rg[31]),
    .side_i  (r_s_q),
    .valid_o (d2_vld),
    .quo_o   (d2_quo),
    .ovf_o   (d2_ovf),
    .neg_o   (d2_neg),
    .side_o  (d2_side)
  );

  assign d2_s = s2_t'(d2_side);

  // void fraction clamp; zero gas density saturates by the sign of g
  always_comb begin
    if (d2_s.rec.rg == '0) begin
      alpha_d = d2_s.g[31] ? 16'd0 : ALPHA_MAX;
    end else if (d2_neg) begin
      alpha_d = 16'd0;
    end else if (d2_ovf || d2_quo > ALPHA_QW'(ALPHA_MAX)) begin
      alpha_d = ALPHA_MAX;
    end else begin
      alpha_d = d2_quo[15:0];
    end
  end

  always_comb begin
    c_d       = '0;
    c_d.rec   = b_s_q.rec;
    c_d.cons  = b_s_q.cons;
    c_d.rho   = b_s_q.rho;
    c_d.alpha = b_alpha_q;
    c_d.sg    = 32'(b_pg_q >>> 16);
    c_d.sl    = 32'(b_pl_q >>> 16);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_s_q     <= d2_s;
      a_alpha_q <= alpha_d;

      b_s_q     <= a_s_q;
      b_alpha_q <= a_alpha_q;
      b_ar_q    <= 64'(signed'({1'b0, a_alpha_q})) * 64'(a_s_q.rec.rg);
      b_rv_q    <= 64'(a_s_q.rho) * 64'(a_s_q.rec.vol);
      b_pg_q    <= 64'(signed'({1'b0, ONE_Q16 - 17'(a_alpha_q)})) * 64'(slip_q);
      b_pl_q    <= 64'(signed'({1'b0, a_alpha_q})) * 64'(slip_q);

      c_s_q     <= c_d;
      c_nrl_q   <= (64'(b_s_q.rho) <<< 16) - b_ar_q;
      c_rv_q    <= b_rv_q;
    end
  end

  assign nrl_mag = abs64(c_nrl_q);
  assign rv_mag  = abs64(c_rv_q);

  tpcsc_div #(
    .NUM_W (49), .DEN_W (17), .Q_W (DIV_QW), .SIDE_W ($bits(s3_t))
  ) u_div_liq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (c_vld_q),
    .num_i   (nrl_mag[48:0]),
    .den_i   (ONE_Q16 - 17'(c_s_q.alpha)),
    .neg_i   (c_nrl_q[63]),
    .side_i  (c_s_q),
    .valid_o (d3_vld),
    .quo_o   (d3l_quo),
    .ovf_o   (d3l_ovf),
    .neg_o   (d3l_neg),
    .side_o  (d3_side)
  );

  tpcsc_div #(
    .NUM_W (64), .DEN_W (64), .Q_W (DIV_QW), .SIDE_W (1)
  ) u_div_vel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (c_vld_q),
    .num_i   ({abs32(c_s_q.rec.mom), 32'd0}),
    .den_i   (rv_mag),
    .neg_i   (c_s_q.rec.mom[31] ^ c_rv_q[63]),
    .side_i  (1'b0),
    .valid_o (),
    .quo_o   (d3v_quo),
    .ovf_o   (d3v_ovf),
    .neg_o   (d3v_neg),
    .side_o  ()
  );

  assign d3_s   = s3_t'(d3_side);
  assign rl_new = div_sat32(d3l_quo, d3l_ovf, d3l_neg);
  assign vm_raw = div_sat32(d3v_quo, d3v_ovf, d3v_neg);
  assign vm     = (d3_s.rho == '0) ? '0 : vm_raw;
  assign vg     = sat33(33'(vm) + 33'(d3_s.sg));
  assign vl     = sat33(33'(vm) - 33'(d3_s.sl));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cell_tag_q <= d3_s.rec.idx;
      err_q      <= 1'b0;
      rho_q      <= '0;
      alpha_q    <= '0;
      rl_q       <= '0;
      vm_q       <= '0;
      vg_q       <= '0;
      vl_q       <= '0;
      mmix_q     <= '0;
      mgas_q     <= '0;
      mom_q      <= '0;
      if (d3_s.rec.req) begin
        mmix_q <= d3_s.cons.mmix;
        mgas_q <= d3_s.cons.mgas;
        mom_q  <= d3_s.cons.mom;
      end else if (d3_s.rec.vol <= 0) begin
        err_q <= 1'b1;
      end else begin
        rho_q   <= d3_s.rho;
        alpha_q <= d3_s.alpha;
        rl_q    <= rl_new;
        vm_q    <= vm;
        vg_q    <= vg;
        vl_q    <= vl;
      end
    end
  end

  assign out_valid_o            = out_valid_q;
  assign cell_tag_o             = cell_tag_q;
  assign volume_error_o         = err_q;
  assign mixture_density_out_o  = rho_q;
  assign void_fraction_out_o    = alpha_q;
  assign liquid_density_out_o   = rl_q;
  assign mixture_velocity_out_o = vm_q;
  assign gas_velocity_out_o     = vg_q;
  assign liquid_velocity_out_o  = vl_q;
  assign mass_mixture_out_o     = mmix_q;
  assign mass_gas_out_o         = mgas_q;
  assign momentum_out_o         = mom_q;

  `TPCSC_ASSERT(a_err_zero, out_valid_q && err_q |-> rho_q == '0 && mmix_q == '0 && vg_q == '0)
  `TPCSC_ASSERT(a_alpha_max, out_valid_q |-> alpha_q <= ALPHA_MAX)
  `TPCSC_ASSERT_NEXT(a_fill, in_valid_i && !in_stall_o, f1_vld_q)
  `TPCSC_ASSERT(a_req_excl, out_valid_q && mmix_q != '0 |-> !err_q && rho_q == '0)

endmodule

// ===== hdl/tpcsc_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with sideband
// depends on nothing; quotient saturation is left to the caller via ovf_o
module tpcsc_div #(
  parameter int NUM_W  = 48,
  parameter int DEN_W  = 32,
  parameter int Q_W    = 33,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic              neg_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    quo_o,
  output logic              ovf_o,
  output logic              neg_o,
  output logic [SIDE_W-1:0] side_o
);
  localparam int CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic              vld_q  [Q_W+1];
  logic [NUM_W-1:0]  rem_q  [Q_W+1];
  logic [DEN_W-1:0]  den_q  [Q_W+1];
  logic [Q_W-1:0]    quo_q  [Q_W+1];
  logic              ovf_q  [Q_W+1];
  logic              neg_q  [Q_W+1];
  logic [SIDE_W-1:0] side_q [Q_W+1];

  logic ovf_in;
  // quotient would not fit in Q_W bits
  assign ovf_in = CMP_W'(num_i) >= (CMP_W'(den_i) << Q_W);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_i;
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      ovf_q[0]  <= ovf_in;
      neg_q[0]  <= neg_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar i = 1; i <= Q_W; i++) begin : g_step
    localparam int K = Q_W - i;
    logic [CMP_W-1:0] sub_w;
    logic [CMP_W-1:0] rem_w;
    logic             take_w;

    assign sub_w  = CMP_W'(den_q[i-1]) << K;
    assign rem_w  = CMP_W'(rem_q[i-1]);
    assign take_w = rem_w >= sub_w;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= take_w ? NUM_W'(rem_w - sub_w) : rem_q[i-1];
        den_q[i]  <= den_q[i-1];
        quo_q[i]  <= {quo_q[i-1][Q_W-2:0], take_w};
        ovf_q[i]  <= ovf_q[i-1];
        neg_q[i]  <= neg_q[i-1];
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign valid_o = vld_q[Q_W];
  assign quo_o   = quo_q[Q_W];
  assign ovf_o   = ovf_q[Q_W];
  assign neg_o   = neg_q[Q_W];
  assign side_o  = side_q[Q_W];

endmodule

// ===== sim/two_phase_cell_state_converter_core_tb.sv =====
// testbench of the two-phase cell state converter: random and directed cells,
// results checked against a predictor of the fixed-point datapath
// depends on tpcsc_pkg and two_phase_cell_state_converter_core
`timescale 1ns / 1ps

module two_phase_cell_state_converter_core_tb;
  import tpcsc_pkg::*;

  typedef struct {
    logic        req;
    logic [15:0] idx;
    logic [31:0] vol, mm, mg, mom, rg, rl, rho, vm;
    logic [16:0] alpha;
  } cell_rec_t;

  typedef struct {
    logic [15:0] tag;
    logic        verr;
    logic [31:0] rho, rl, vm, vg, vl, mmix, mgas, mom;
    logic [15:0] alpha;
  } cell_res_t;

  localparam int   WATCHDOG_LIMIT = 4000;
  localparam int   HOLD_CYCLES    = 400;
  localparam logic REQ_TO_PRIM    = 1'b0;
  localparam logic REQ_TO_CONS    = 1'b1;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic signed [31:0] cfg_slip_velocity_i;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic req_type_i;
  logic [15:0] cell_index_i;
  logic signed [31:0] cell_volume_i, mass_mixture_in_i, mass_gas_in_i, momentum_in_i;
  logic signed [31:0] gas_density_in_i, liquid_density_in_i, mixture_density_in_i;
  logic signed [31:0] mixture_velocity_in_i;
  logic [16:0] void_fraction_in_i;
  logic [15:0] cell_tag_o, void_fraction_out_o;
  logic volume_error_o;
  logic signed [31:0] mixture_density_out_o, liquid_density_out_o, mixture_velocity_out_o;
  logic signed [31:0] gas_velocity_out_o, liquid_velocity_out_o;
  logic signed [31:0] mass_mixture_out_o, mass_gas_out_o, momentum_out_o;

  two_phase_cell_state_converter_core uut (.*);

  cell_rec_t pending_cells[$];
  cell_res_t expected_states[$];
  longint    slip_q16;
  int        errors, watchdog, cells_done, err_cells, cons_cells;
  bit        in_taken, calm, hold_req;
  int        hold_cnt;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint sat_s32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    return sat_s32(p >>> 16);
  endfunction

  // quotient truncated toward zero, magnitude done unsigned
  function automatic longint qdiv(longint num, longint den);
    logic [63:0] un, ud, q;
    bit neg;
    neg = (num < 0) != (den < 0);
    un = num < 0 ? 64'd0 - num : num;
    ud = den < 0 ? 64'd0 - den : den;
    q = un / ud;
    if (neg) return (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
    return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
  endfunction

  function automatic cell_res_t convert_cell(cell_rec_t c);
    cell_res_t r;
    longint vol, rg, rho, g, a, vm;
    r = '{default: '0};
    r.tag = c.idx;
    vol = longint'($signed(c.vol));
    rg = longint'($signed(c.rg));
    if (c.req == REQ_TO_CONS) begin
      r.mmix = 32'(qmul($signed(c.rho), vol));
      r.mgas = 32'(qmul(qmul(longint'(c.alpha), rg), vol));
      r.mom = 32'(qmul(qmul($signed(c.rho), $signed(c.vm)), vol));
      return r;
    end
    if (vol <= 0) begin
      r.verr = 1'b1;
      return r;
    end
    rho = qdiv(longint'($signed(c.mm)) * 65536, vol);
    g = qdiv(longint'($signed(c.mg)) * 65536, vol);
    if (rho <= 0) rho = longint'($signed(c.rl)) >>> 1;
    if (rg == 0) a = g < 0 ? 0 : 65470;
    else begin
      a = qdiv(g * 65536, rg);
      if (a < 0) a = 0;
      if (a > 65470) a = 65470;
    end
    r.rl = 32'(qdiv(rho * 65536 - a * rg, 65536 - a));
    vm = (rho == 0) ? 0 : qdiv(longint'($signed(c.mom)) <<< 32, rho * vol);
    if (a == 0) begin
      r.vg = 32'(sat_s32(vm + slip_q16));
      r.vl = 32'(vm);
    end else begin
      r.vg = 32'(sat_s32(vm + qmul(65536 - a, slip_q16)));
      r.vl = 32'(sat_s32(vm - qmul(a, slip_q16)));
    end
    r.rho = 32'(rho);
    r.alpha = a[15:0];
    r.vm = 32'(vm);
    return r;
  endfunction

  function automatic logic [31:0] pick32(int mode);
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom;
      default: return mode ? $urandom_range(1 << 12, 1 << 21) : $urandom;
    endcase
  endfunction

  function automatic cell_rec_t rand_cell();
    cell_rec_t c;
    bit wf;
    wf = $urandom_range(0, 3) != 0;
    c.req = 1'($urandom_range(0, 1));
    c.idx = 16'($urandom);
    c.vol = wf ? $urandom_range(1 << 12, 1 << 20) : pick32(0);
    c.mm = wf ? $urandom_range(0, 1 << 22) - (1 << 18) : pick32(0);
    c.mg = wf ? $urandom_range(0, 1 << 18) - (1 << 14) : pick32(0);
    c.mom = wf ? $urandom_range(0, 1 << 24) - (1 << 23) : pick32(0);
    c.rg = ($urandom_range(0, 9) == 0) ? 32'h0 : pick32(wf);
    c.rl = pick32(wf);
    c.rho = pick32(wf);
    c.vm = wf ? $urandom_range(0, 1 << 22) - (1 << 21) : pick32(0);
    c.alpha = ($urandom_range(0, 7) == 0) ? 17'd65536 : 17'($urandom_range(0, 65535));
    return c;
  endfunction

  function automatic cell_rec_t mk(logic req, logic [31:0] vol, logic [31:0] mm,
                                   logic [31:0] mg, logic [31:0] rg, logic [31:0] rl);
    cell_rec_t c;
    c = rand_cell();
    c.req = req; c.vol = vol; c.mm = mm; c.mg = mg; c.rg = rg; c.rl = rl;
    return c;
  endfunction

  task automatic cfg_write(logic [31:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_slip_velocity_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    slip_q16 = longint'($signed(v));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_cells.size() != 0 || expected_states.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // sender: a payload stays put until its transaction is taken
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (pending_cells.size() != 0 && (calm || $urandom_range(0, 99) >= 29)) begin
        cell_rec_t c;
        c = pending_cells.pop_front();
        in_valid_i <= 1'b1;
        req_type_i <= c.req; cell_index_i <= c.idx; cell_volume_i <= c.vol;
        mass_mixture_in_i <= c.mm; mass_gas_in_i <= c.mg; momentum_in_i <= c.mom;
        gas_density_in_i <= c.rg; liquid_density_in_i <= c.rl;
        mixture_density_in_i <= c.rho; mixture_velocity_in_i <= c.vm;
        void_fraction_in_i <= c.alpha;
      end else in_valid_i <= 1'b0;
    end
  end

  // receiver with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req && hold_cnt == 0) hold_cnt <= HOLD_CYCLES;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
    out_stall_i <= (hold_cnt > 1) || (!calm && $urandom_range(0, 99) < 29);
  end

  task automatic chk(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $realtime, name, e, a);
    end
  endtask

  always @(posedge clk_i) begin
    in_taken <= in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      cell_rec_t c;
      c.req = req_type_i; c.idx = cell_index_i; c.vol = cell_volume_i;
      c.mm = mass_mixture_in_i; c.mg = mass_gas_in_i; c.mom = momentum_in_i;
      c.rg = gas_density_in_i; c.rl = liquid_density_in_i;
      c.rho = mixture_density_in_i; c.vm = mixture_velocity_in_i;
      c.alpha = void_fraction_in_i;
      expected_states.push_back(convert_cell(c));
      cells_done++;
      if (c.req == REQ_TO_CONS) cons_cells++;
      else if ($signed(c.vol) <= 0) err_cells++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_states.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, tag %h", $realtime, cell_tag_o);
      end else begin
        cell_res_t e;
        e = expected_states.pop_front();
        chk("tag", 32'(e.tag), 32'(cell_tag_o));
        chk("volume error", 32'(e.verr), 32'(volume_error_o));
        chk("rho", e.rho, mixture_density_out_o);
        chk("alpha", 32'(e.alpha), 32'(void_fraction_out_o));
        chk("rho liq", e.rl, liquid_density_out_o);
        chk("vel mix", e.vm, mixture_velocity_out_o);
        chk("vel gas", e.vg, gas_velocity_out_o);
        chk("vel liq", e.vl, liquid_velocity_out_o);
        chk("mass mix", e.mmix, mass_mixture_out_o);
        chk("mass gas", e.mgas, mass_gas_out_o);
        chk("momentum", e.mom, momentum_out_o);
      end
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] slips[5];
    cell_rec_t c;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0; cfg_slip_velocity_i = '0;
    in_valid_i = 1'b0; out_stall_i = 1'b0;
    req_type_i = '0; cell_index_i = '0; cell_volume_i = '0; mass_mixture_in_i = '0;
    mass_gas_in_i = '0; momentum_in_i = '0; gas_density_in_i = '0;
    liquid_density_in_i = '0; mixture_density_in_i = '0; mixture_velocity_in_i = '0;
    void_fraction_in_i = '0;
    slip_q16 = 0; errors = 0; watchdog = 0; cells_done = 0; err_cells = 0; cons_cells = 0;
    in_taken = 0; calm = 0; hold_req = 0; hold_cnt = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed cells under the reset slip
    c = mk(REQ_TO_CONS, 32'h7fffffff, 0, 0, 32'h7fffffff, 0);
    c.rho = 32'h7fffffff; c.vm = 32'h80000000; c.alpha = 17'd65536;
    pending_cells.push_back(c);
    c = mk(REQ_TO_CONS, 32'h80000000, 0, 0, 32'h80000000, 0);
    c.rho = 32'h80000000; c.vm = 32'h7fffffff; c.alpha = 17'd0;
    pending_cells.push_back(c);
    pending_cells.push_back(mk(REQ_TO_PRIM, 0, 32'h10000, 0, 32'h10000, 0));
    pending_cells.push_back(mk(REQ_TO_PRIM, 32'h80000000, 32'h10000, 0, 32'h10000, 0));
    // non-positive density falls back to half the liquid density
    pending_cells.push_back(mk(REQ_TO_PRIM, 32'h10000, 32'hffff0000, 0, 32'h10000,
                               32'h30001));
    pending_cells.push_back(mk(REQ_TO_PRIM, 32'h10000, 0, 0, 32'h10000, 32'hfffd0001));
    // zero mixture density gives zero velocity
    pending_cells.push_back(mk(REQ_TO_PRIM, 32'h10000, 0, 0, 32'h10000, 0));
    // zero gas density, gas mass negative and positive
    pending_cells.push_back(mk(REQ_TO_PRIM, 32'h10000, 32'h20000, 32'hffff0000, 0,
                               32'h10000));
    pending_cells.push_back(mk(REQ_TO_PRIM, 32'h10000, 32'h20000, 32'h8000, 0, 32'h10000));
    // void fraction clamp at 0.999 and below zero
    pending_cells.push_back(mk(REQ_TO_PRIM, 32'h10000, 32'h20000, 32'h50000, 32'h10000,
                               32'h10000));
    pending_cells.push_back(mk(REQ_TO_PRIM, 32'h10000, 32'h20000, 32'hfffb0000,
                               32'h10000, 32'h10000));
    pending_cells.push_back(mk(REQ_TO_PRIM, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                               32'h1, 32'h7fffffff));
    pending_cells.push_back(mk(REQ_TO_PRIM, 32'h1, 32'h80000000, 32'h80000000,
                               32'h80000000, 32'h80000000));
    pending_cells.push_back(mk(REQ_TO_PRIM, 32'h1, 32'h7fffffff, 32'h1, 32'h7fffffff,
                               32'h7fffffff));
    for (int k = 0; k < 6; k++) pending_cells.push_back(rand_cell());
    drain();

    slips = '{32'h7fffffff, 32'h80000000, $urandom, 32'h00010000, 32'h0};
    for (int ph = 0; ph < 5; ph++) begin
      cfg_write(slips[ph]);
      calm = (ph == 3);
      for (int k = 0; k < 310; k++) pending_cells.push_back(rand_cell());
      if (ph == 1) begin
        repeat (20) @(posedge clk_i);
        hold_req = 1'b1;
        @(posedge clk_i);
        hold_req = 1'b0;
      end
      drain();
    end

    $display("%0d cells checked: %0d to conserved, %0d volume errors, five slip settings",
             cells_done, cons_cells, err_cells);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/tpcsc_pkg.sv
hdl/tpcsc_div.sv
hdl/two_phase_cell_state_converter_core.sv
sim/two_phase_cell_state_converter_core_tb.sv
